// File: rtl/core/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// shared types and constants for the bitmap block allocator
// ---------------------------------------------------------------------------
package bba_pkg;

  // bitmap storage word
  localparam int WORD_W = 32;
  localparam int WBIT_W = 5;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int BN_W     = 10;
  localparam int DCOUNT_W = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT = 1'd1;

  // outcome of a search over one bitmap word
  typedef struct packed {
    logic              hit;
    logic [WBIT_W-1:0] bit_idx;
  } scan_res_t;

endpackage

// File: rtl/core/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a used-flag bitmap held in block memory
// ---------------------------------------------------------------------------
// The used flags live in a 32-bit-word memory with a registered read port,
// flag i standing for block data_start + i. The region spans
// min(data_count, MAX_BLOCKS - data_start) flags, none when data_start is at
// or past MAX_BLOCKS. One request is worked on at a time; the input is ready
// again as soon as the result sits in the output register, even if that
// word has not yet been taken. An allocate reads the 32-flag words in turn
// from the start of the region up to the one holding the first free flag
// (at most ceil(count/32) of them), one word a cycle on the memory read
// port, and writes that word back with the flag set. A free reads the word,
// then modifies and writes it back; outside the region it writes nothing.
// A clear request sweeps the memory one word a cycle, writing every word to
// zero. After reset the same sweep runs before the first request is taken.
// Register writes change the region only, never the flags.
// ---------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [BN_W-1:0]      block_number,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [BN_W-1:0]      block_number_out,
  // register write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DCOUNT_W-1:0]  cfg_data
);

  // memory geometry
  localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IW     = $clog2(NWORDS * WORD_W);
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  // common width for counts, block indexes and compares
  localparam int XW0    = (CW > DCOUNT_W) ? CW : DCOUNT_W;
  localparam int XW     = (XW0 > IW + 1) ? XW0 : IW + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,   // zero-fill sweep
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,   // one word per cycle
    S_FREE  = 5'b01000,   // write back word with flag cleared
    S_DONE  = 5'b10000    // hand result to output register
  } state_t;

  state_t state, state_next;

  // configuration
  logic [BN_W-1:0]     data_start;
  logic [DCOUNT_W-1:0] data_count;

  // working registers
  logic [AW-1:0]       scan_addr, scan_addr_next;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [XW-1:0]       cnt_q, cnt_q_next;
  logic [XW-1:0]       rel_q, rel_q_next;
  logic                clr_req, clr_req_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [BN_W-1:0]     res_block, res_block_next;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // region arithmetic
  logic [XW-1:0] ds_x;
  logic [XW-1:0] room;
  logic [XW-1:0] usable;
  logic [XW-1:0] blk_x;
  logic [XW-1:0] rel;
  logic          free_oor;
  logic [XW-1:0] left;
  logic [XW-1:0] next_base;
  logic [XW-1:0] alloc_idx;
  logic [XW-1:0] alloc_sum;
  scan_res_t     sres;

  logic in_fire;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // usable region size
  always_comb begin
    ds_x = XW'(data_start);
    room = XW'(MAX_BLOCKS) - ds_x;
    if (ds_x >= XW'(MAX_BLOCKS)) begin
      usable = '0;
    end else if (XW'(data_count) < room) begin
      usable = XW'(data_count);
    end else begin
      usable = room;
    end
  end

  // free range check on the incoming block number
  assign blk_x    = XW'(block_number);
  assign rel      = blk_x - ds_x;
  assign free_oor = (blk_x < ds_x) || (rel >= usable);

  // scan of the word just read
  assign left      = cnt_q - (XW'(scan_addr) << WBIT_W);
  assign next_base = (XW'(scan_addr) + XW'(1)) << WBIT_W;
  assign alloc_idx = (XW'(scan_addr) << WBIT_W) + XW'(sres.bit_idx);
  assign alloc_sum = ds_x + alloc_idx;

  bba_word_scan #(
    .XW (XW)
  ) u_scan (
    .word (ram_rdata),
    .left (left),
    .res  (sres)
  );

  bba_bitmap_ram #(
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    scan_addr_next  = scan_addr;
    clr_addr_next   = clr_addr;
    cnt_q_next      = cnt_q;
    rel_q_next      = rel_q;
    clr_req_next    = clr_req;
    res_status_next = res_status;
    res_block_next  = res_block;
    ram_we          = 1'b0;
    ram_waddr       = clr_addr;
    ram_wdata       = '0;
    ram_raddr       = '0;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(NWORDS - 1)) begin
          clr_addr_next = '0;
          state_next    = clr_req ? S_DONE : S_IDLE;
          clr_req_next  = 1'b0;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          res_status_next = STATUS_DONE;
          res_block_next  = '0;
          unique case (req_type)
            REQ_ALLOC: begin
              cnt_q_next     = usable;
              scan_addr_next = '0;
              ram_raddr      = '0;
              if (usable == '0) begin
                res_status_next = STATUS_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            REQ_FREE: begin
              rel_q_next = rel;
              ram_raddr  = rel[AW+WBIT_W-1:WBIT_W];
              if (free_oor) begin
                res_status_next = STATUS_RANGE;
                state_next      = S_DONE;
              end else begin
                state_next = S_FREE;
              end
            end
            REQ_CLEAR: begin
              clr_req_next  = 1'b1;
              clr_addr_next = '0;
              state_next    = S_CLEAR;
            end
            REQ_RSVD: begin
              state_next = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // next word is fetched speculatively
        ram_raddr = scan_addr + AW'(1);
        if (sres.hit) begin
          ram_we          = 1'b1;
          ram_waddr       = scan_addr;
          ram_wdata       = ram_rdata | (WORD_W'(1) << sres.bit_idx);
          res_status_next = STATUS_DONE;
          res_block_next  = alloc_sum[BN_W-1:0];
          state_next      = S_DONE;
        end else if (next_base < cnt_q) begin
          scan_addr_next = scan_addr + AW'(1);
        end else begin
          res_status_next = STATUS_FULL;
          state_next      = S_DONE;
        end
      end

      S_FREE: begin
        ram_we     = 1'b1;
        ram_waddr  = rel_q[AW+WBIT_W-1:WBIT_W];
        ram_wdata  = ram_rdata & ~(WORD_W'(1) << rel_q[WBIT_W-1:0]);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_req    <= 1'b0;
      out_valid  <= 1'b0;
      data_start <= '0;
      data_count <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      clr_req  <= clr_req_next;

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DATA_START: data_start <= cfg_data[BN_W-1:0];
          CFG_DATA_COUNT: data_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    cnt_q      <= cnt_q_next;
    rel_q      <= rel_q_next;
    res_status <= res_status_next;
    res_block  <= res_block_next;
    if (state == S_DONE && out_free) begin
      status           <= res_status;
      block_number_out <= res_block;
    end
  end

endmodule

// File: rtl/core/bba_bitmap_ram.sv
// ---------------------------------------------------------------------------
// bba_bitmap_ram
// one-write one-read word memory holding the used flags, registered read
// ---------------------------------------------------------------------------
module bba_bitmap_ram
  import bba_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bba_word_scan.sv
// ---------------------------------------------------------------------------
// bba_word_scan
// lowest free flag of one bitmap word, limited to the flags inside the region
// ---------------------------------------------------------------------------
module bba_word_scan
  import bba_pkg::*;
#(
  parameter int XW = 11
) (
  input  logic [WORD_W-1:0] word,
  input  logic [XW-1:0]     left,   // flags of the region from this word on
  output scan_res_t         res
);

  logic [WORD_W-1:0] avail;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = !word[b] && (XW'(b) < left);
    end
  end

  // lowest set bit of avail
  always_comb begin
    res.hit     = 1'b0;
    res.bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res.hit     = 1'b1;
        res.bit_idx = WBIT_W'(b);
      end
    end
  end

endmodule
